FILE: hdl/ascl_pkg.sv
`timescale 1ns / 1ps

package ascl_pkg;

  // Character codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_TWO   = 8'h32;
  localparam logic [7:0] CHAR_FOUR  = 8'h34;
  localparam logic [7:0] CHAR_SIX   = 8'h36;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  // Key codes
  localparam logic [7:0] KEY_DIGIT_LO = 8'h30;
  localparam logic [7:0] KEY_DIGIT_HI = 8'h39;
  localparam logic [7:0] KEY_BLANK    = 8'h3A;
  localparam logic [7:0] KEY_START    = 8'h3B;
  localparam logic [7:0] KEY_LEFT     = 8'h3C;
  localparam logic [7:0] KEY_RIGHT    = 8'h3D;
  localparam logic [7:0] KEY_STOP     = 8'h3E;
  localparam logic [7:0] KEY_FINISH   = 8'h3F;

  // Action codes
  localparam logic ACT_KEY  = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Cursor range
  localparam logic [3:0] CURSOR_MIN = 4'd1;
  localparam logic [3:0] CURSOR_MAX = 4'd8;

  // Character 0 is the top byte
  typedef logic [0:7][7:0] text_t;

  localparam text_t RESET_TEXT = {CHAR_ZERO, CHAR_ZERO, CHAR_DASH, CHAR_ZERO,
                                  CHAR_ZERO, CHAR_DASH, CHAR_ZERO, CHAR_ZERO};

  typedef struct packed {
    text_t      chars;
    logic       edit_active;
    logic [3:0] cursor_offset;
    logic       run;
    logic       done;
  } clk_state_t;

  localparam clk_state_t RESET_STATE = '{
    chars:         RESET_TEXT,
    edit_active:   1'b0,
    cursor_offset: 4'd0,
    run:           1'b0,
    done:          1'b0
  };

endpackage

FILE: hdl/ascl_update.sv
`timescale 1ns / 1ps

module ascl_update (
  input  ascl_pkg::clk_state_t cur,
  input  logic                 action,
  input  logic [7:0]           key_code,
  output ascl_pkg::clk_state_t nxt,
  output logic                 blank
);
  import ascl_pkg::*;

  // Advance one second with the byte-wise carry checks, in order
  function automatic text_t advance_second(input text_t t);
    text_t r;
    r = t;
    r[7] = r[7] + 8'd1;
    if (r[7] == CHAR_COLON) begin
      r[7] = CHAR_ZERO;
      r[6] = r[6] + 8'd1;
    end
    if (r[6] == CHAR_SIX) begin
      r[6] = CHAR_ZERO;
      r[4] = r[4] + 8'd1;
    end
    if (r[4] == CHAR_COLON) begin
      r[4] = CHAR_ZERO;
      r[3] = r[3] + 8'd1;
    end
    if (r[3] == CHAR_SIX) begin
      r[3] = CHAR_ZERO;
      r[1] = r[1] + 8'd1;
    end
    if (r[0] < CHAR_TWO) begin
      if (r[1] == CHAR_COLON) begin
        r[1] = CHAR_ZERO;
        r[0] = r[0] + 8'd1;
      end
    end else begin
      if (r[1] == CHAR_FOUR) begin
        r[1] = CHAR_ZERO;
        r[0] = CHAR_ZERO;
      end
    end
    return r;
  endfunction

  logic [2:0] write_idx;

  // Edit position counts from the right end, offset eight wraps to character 0
  assign write_idx = 3'(CURSOR_MAX - cur.cursor_offset);

  // Apply one item to the state
  always_comb begin
    nxt   = cur;
    blank = 1'b0;
    if (!cur.done) begin
      if (action == ACT_TICK) begin
        if (cur.run) begin
          nxt.chars = advance_second(cur.chars);
        end
      end else if (key_code inside {[KEY_DIGIT_LO:KEY_DIGIT_HI]}) begin
        if (cur.edit_active) begin
          nxt.chars[write_idx] = key_code;
          nxt.edit_active      = 1'b0;
          nxt.cursor_offset    = 4'd0;
        end
      end else begin
        case (key_code)
          KEY_BLANK: begin
            blank = 1'b1;
          end
          KEY_START: begin
            nxt.run         = 1'b1;
            nxt.edit_active = 1'b0;
          end
          KEY_LEFT: begin
            nxt.edit_active   = 1'b1;
            nxt.cursor_offset = (cur.cursor_offset < CURSOR_MAX) ?
                                cur.cursor_offset + 4'd1 : CURSOR_MIN;
          end
          KEY_RIGHT: begin
            nxt.edit_active   = 1'b1;
            nxt.cursor_offset = (cur.cursor_offset > CURSOR_MIN) ?
                                cur.cursor_offset - 4'd1 : CURSOR_MAX;
          end
          KEY_STOP: begin
            nxt.run         = 1'b0;
            nxt.edit_active = 1'b0;
          end
          KEY_FINISH: begin
            nxt.done = 1'b1;
            nxt.run  = 1'b0;
          end
          default: begin
            nxt = cur;
          end
        endcase
      end
    end
  end

endmodule

FILE: hdl/ascii_clock_with_cursor_edit.sv
`timescale 1ns / 1ps

// ASCII time-of-day clock "HH-MM-SS" with a one-character edit cursor.
// Input channel (in_valid / in_ready): action selects a key press or a
// one-second tick, key_code carries the key. Output channel (out_valid /
// out_ready): one result per input item, showing the text and flags after
// that item; blank_display is set only for the item that carried the
// blank key.
// An item passes through the input register, then the result register.
// Throughput: one item per cycle unless the receiver stalls; the update
// of the clock state is a single pass of combinational logic between the
// input register and the result register.
// When the receiver stalls, the result register holds and the input
// register keeps one more item; in_ready drops only while both are full.
// Reset clears both stages and sets the text to 00-00-00, clock stopped,
// no cursor, not finished.
module ascii_clock_with_cursor_edit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [7:0]  key_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] time_text,
  output logic        cursor_active,
  output logic [3:0]  cursor_position,
  output logic        clock_running,
  output logic        blank_display,
  output logic        finished
);
  import ascl_pkg::*;

  logic       s1_valid;
  logic       s1_action;
  logic [7:0] s1_key;
  logic       out_free;
  logic       s1_adv;

  clk_state_t st;
  clk_state_t st_next;
  logic       blank_next;

  assign out_free = !out_valid || out_ready;
  assign s1_adv   = s1_valid && out_free;
  assign in_ready = !s1_valid || out_free;

  // Input register: load on transfer, drop when passed on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_action <= action;
      s1_key    <= key_code;
    end
  end

  ascl_update u_update (
    .cur      (st),
    .action   (s1_action),
    .key_code (s1_key),
    .nxt      (st_next),
    .blank    (blank_next)
  );

  // Clock state: advance once per item passed to the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= RESET_STATE;
    end else if (s1_adv) begin
      st <= st_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      time_text       <= st_next.chars;
      cursor_active   <= st_next.edit_active;
      cursor_position <= st_next.edit_active ? st_next.cursor_offset : 4'd0;
      clock_running   <= st_next.run;
      blank_display   <= blank_next;
      finished        <= st_next.done;
    end
  end

  // Cursor offset stays in range while editing
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    st.edit_active |-> (st.cursor_offset >= CURSOR_MIN && st.cursor_offset <= CURSOR_MAX))
    else $error("cursor offset out of range while editing");

  // Finish is permanent
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    st.done |=> st.done)
    else $error("finished flag cleared");

  // A finished clock never runs
  a_done_stopped: assert property (@(posedge clk) disable iff (rst)
    st.done |-> !st.run)
    else $error("clock running after finish");

  // An item leaving the input register lands in the result register
  a_adv_result: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> out_valid)
    else $error("item lost between stages");

endmodule
